FILE: rtl/minimax_progression_fit_macros.svh
`ifndef MINIMAX_PROGRESSION_FIT_MACROS_SVH
`define MINIMAX_PROGRESSION_FIT_MACROS_SVH

// same-cycle implication
`define MPF_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("minimax_progression_fit check failed");

// next-cycle implication
`define MPF_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("minimax_progression_fit check failed");

`endif

FILE: rtl/mpf_pkg.sv
package mpf_pkg;

   localparam int SAMPLE_W = 32;
   localparam int FRAC_W   = 16;
   localparam int DEV_W    = 48;
   localparam int NUM_W    = 53;
   localparam int QUO_W    = NUM_W + 1;

   localparam logic signed [QUO_W-1:0] SLOPE_MIN = {1'b1, {(QUO_W-1){1'b0}}};
   localparam logic signed [QUO_W-1:0] SLOPE_MAX = {1'b0, {(QUO_W-1){1'b1}}};

   typedef enum logic [3:0] {
      ST_LOAD,
      ST_MID,
      ST_ANCHOR_RD,
      ST_ANCHOR_LD,
      ST_ANCHOR_INIT,
      ST_SAMPLE_RD,
      ST_SAMPLE_LD,
      ST_DIV_WAIT,
      ST_UPDATE,
      ST_ANCHOR_END,
      ST_FINISH
   } state_type;

   typedef struct packed {
      logic load;
      logic search_init;
      logic calc_mid;
      logic anchor_rd;
      logic anchor_ld;
      logic anchor_init;
      logic next_sample;
      logic div_start;
      logic slope_update;
      logic flip_sign;
      logic next_anchor;
      logic set_high;
      logic set_low;
      logic finish;
   } cmd_type;

   typedef struct packed {
      logic last_i;
      logic i_is_v;
      logic div_done;
      logic fits;
      logic sign;
      logic last_anchor;
      logic last_step;
      logic out_free;
   } status_type;

endpackage

FILE: rtl/mpf_div.sv
module mpf_div
   import mpf_pkg::*;
#(
   parameter int DIV_W = 10
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   input  logic                    round_up,
   input  logic signed [NUM_W-1:0] numerator,
   input  logic [DIV_W-1:0]        divisor,
   output logic                    done,
   output logic signed [QUO_W-1:0] quotient
);

   localparam int CYC_W = $clog2(NUM_W + 1);

   logic                    busy_ff, busy_in;
   logic                    done_ff, done_in;
   logic [CYC_W-1:0]        cnt_ff, cnt_in;
   logic [DIV_W-1:0]        rem_ff, rem_in;
   logic [NUM_W-1:0]        quo_ff, quo_in;
   logic [DIV_W-1:0]        div_ff, div_in;
   logic                    neg_ff, neg_in;
   logic                    round_ff, round_in;
   logic signed [QUO_W-1:0] result_ff, result_in;

   logic [DIV_W:0]          rem_sh;
   logic                    bit_q;
   logic [DIV_W-1:0]        rem_next;
   logic [NUM_W-1:0]        quo_next;
   logic                    inc;
   logic [QUO_W-1:0]        mag;

   always_comb begin
      rem_sh   = {rem_ff, quo_ff[NUM_W-1]};
      bit_q    = (rem_sh >= {1'b0, div_ff});
      rem_next = bit_q ? DIV_W'(rem_sh - {1'b0, div_ff}) : rem_sh[DIV_W-1:0];
      quo_next = {quo_ff[NUM_W-2:0], bit_q};
      inc      = (rem_next != '0) && (neg_ff != round_ff);
      mag      = {1'b0, quo_next} + QUO_W'(inc);

      busy_in   = busy_ff;
      done_in   = 1'b0;
      cnt_in    = cnt_ff;
      rem_in    = rem_ff;
      quo_in    = quo_ff;
      div_in    = div_ff;
      neg_in    = neg_ff;
      round_in  = round_ff;
      result_in = result_ff;
      if (start) begin
         busy_in  = 1'b1;
         cnt_in   = '0;
         rem_in   = '0;
         quo_in   = numerator[NUM_W-1] ? NUM_W'(-numerator) : numerator;
         div_in   = divisor;
         neg_in   = numerator[NUM_W-1];
         round_in = round_up;
      end else if (busy_ff) begin
         rem_in = rem_next;
         quo_in = quo_next;
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == CYC_W'(NUM_W - 1)) begin
            busy_in   = 1'b0;
            done_in   = 1'b1;
            result_in = neg_ff ? $signed(-mag) : $signed(mag);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff    <= cnt_in;
      rem_ff    <= rem_in;
      quo_ff    <= quo_in;
      div_ff    <= div_in;
      neg_ff    <= neg_in;
      round_ff  <= round_in;
      result_ff <= result_in;
   end

   assign done     = done_ff;
   assign quotient = result_ff;

endmodule

FILE: rtl/mpf_ctrl.sv
module mpf_ctrl
   import mpf_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   input  logic       req_tlast,
   output logic       req_tready,
   input  status_type status,
   output cmd_type    cmd
);

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_LOAD;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in   = state_ff;
      cmd        = '0;
      req_tready = 1'b0;
      case (state_ff)
         ST_LOAD: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.load = 1'b1;
               if (req_tlast) begin
                  cmd.search_init = 1'b1;
                  state_in        = ST_MID;
               end
            end
         end
         ST_MID: begin
            cmd.calc_mid = 1'b1;
            state_in     = ST_ANCHOR_RD;
         end
         ST_ANCHOR_RD: begin
            cmd.anchor_rd = 1'b1;
            state_in      = ST_ANCHOR_LD;
         end
         ST_ANCHOR_LD: begin
            cmd.anchor_ld = 1'b1;
            state_in      = ST_ANCHOR_INIT;
         end
         ST_ANCHOR_INIT: begin
            cmd.anchor_init = 1'b1;
            state_in        = ST_SAMPLE_RD;
         end
         ST_SAMPLE_RD: begin
            state_in = status.last_i ? ST_ANCHOR_END : ST_SAMPLE_LD;
         end
         ST_SAMPLE_LD: begin
            if (status.i_is_v) begin
               cmd.next_sample = 1'b1;
               state_in        = ST_SAMPLE_RD;
            end else begin
               cmd.div_start = 1'b1;
               state_in      = ST_DIV_WAIT;
            end
         end
         ST_DIV_WAIT: begin
            if (status.div_done) begin
               state_in = ST_UPDATE;
            end
         end
         ST_UPDATE: begin
            cmd.slope_update = 1'b1;
            cmd.next_sample  = 1'b1;
            state_in         = ST_SAMPLE_RD;
         end
         ST_ANCHOR_END: begin
            if (status.fits || (status.sign && status.last_anchor)) begin
               cmd.set_high = status.fits;
               cmd.set_low  = !status.fits;
               state_in     = status.last_step ? ST_FINISH : ST_MID;
            end else if (!status.sign) begin
               cmd.flip_sign = 1'b1;
               state_in      = ST_ANCHOR_INIT;
            end else begin
               cmd.next_anchor = 1'b1;
               state_in        = ST_ANCHOR_RD;
            end
         end
         ST_FINISH: begin
            if (status.out_free) begin
               cmd.finish = 1'b1;
               state_in   = ST_LOAD;
            end
         end
         default: begin
            state_in = ST_LOAD;
         end
      endcase
   end

endmodule

FILE: rtl/mpf_datapath.sv
module mpf_datapath
   import mpf_pkg::*;
#(
   parameter int MAX_SAMPLES  = 1024,
   parameter int BISECT_STEPS = 48
) (
   input  logic                clock,
   input  logic                reset,
   input  cmd_type             cmd,
   output status_type          status,
   input  logic [SAMPLE_W-1:0] req_tdata,
   output logic                rsp_tvalid,
   input  logic                rsp_tready,
   output logic [DEV_W-1:0]    rsp_tdata
);

   localparam int IDX_W  = $clog2(MAX_SAMPLES);
   localparam int CNT_W  = $clog2(MAX_SAMPLES + 1);
   localparam int STEP_W = $clog2(BISECT_STEPS);

   logic [SAMPLE_W-1:0] mem [MAX_SAMPLES];

   logic [CNT_W-1:0]        count_ff, count_in;
   logic [CNT_W-1:0]        v_ff, v_in;
   logic [CNT_W-1:0]        i_ff, i_in;
   logic [STEP_W-1:0]       step_ff, step_in;
   logic                    sign_ff, sign_in;
   logic [DEV_W-1:0]        low_ff, low_in;
   logic [DEV_W-1:0]        high_ff, high_in;
   logic [DEV_W-1:0]        mid_ff, mid_in;
   logic [SAMPLE_W-1:0]     rd_data_ff;
   logic [SAMPLE_W-1:0]     av_ff, av_in;
   logic signed [NUM_W-1:0] anchor_ff, anchor_in;
   logic signed [QUO_W-1:0] slope_low_ff, slope_low_in;
   logic signed [QUO_W-1:0] slope_high_ff, slope_high_in;
   logic                    out_valid_ff, out_valid_in;
   logic [DEV_W-1:0]        out_data_ff, out_data_in;

   logic [IDX_W-1:0]        rd_addr;
   logic                    not_full;
   logic                    i_lt_v;
   logic [IDX_W-1:0]        gap;
   logic signed [NUM_W-1:0] x_ext;
   logic signed [NUM_W-1:0] scaled_v;
   logic signed [NUM_W-1:0] scaled_i;
   logic signed [NUM_W-1:0] lo_pt;
   logic signed [NUM_W-1:0] hi_pt;
   logic signed [NUM_W-1:0] lo_num;
   logic signed [NUM_W-1:0] hi_num;
   logic signed [QUO_W-1:0] lo_quo;
   logic signed [QUO_W-1:0] hi_quo;
   logic                    lo_done;
   logic                    hi_done;
   logic [DEV_W:0]          mid_sum;

   assign not_full = (count_ff != CNT_W'(MAX_SAMPLES));
   assign rd_addr  = cmd.anchor_rd ? v_ff[IDX_W-1:0] : i_ff[IDX_W-1:0];
   assign i_lt_v   = (i_ff < v_ff);
   assign gap      = i_lt_v ? IDX_W'(v_ff - i_ff) : IDX_W'(i_ff - v_ff);
   assign x_ext    = $signed({{(NUM_W-DEV_W){1'b0}}, mid_ff});
   assign scaled_v = NUM_W'($signed({av_ff, {FRAC_W{1'b0}}}));
   assign scaled_i = NUM_W'($signed({rd_data_ff, {FRAC_W{1'b0}}}));
   assign lo_pt    = scaled_i - x_ext;
   assign hi_pt    = scaled_i + x_ext;
   assign lo_num   = i_lt_v ? anchor_ff - hi_pt : lo_pt - anchor_ff;
   assign hi_num   = i_lt_v ? anchor_ff - lo_pt : hi_pt - anchor_ff;
   assign mid_sum  = {1'b0, low_ff} + {1'b0, high_ff};

   mpf_div #(.DIV_W(IDX_W)) u_div_low (
      .clock     (clock),
      .reset     (reset),
      .start     (cmd.div_start),
      .round_up  (1'b0),
      .numerator (lo_num),
      .divisor   (gap),
      .done      (lo_done),
      .quotient  (lo_quo)
   );

   mpf_div #(.DIV_W(IDX_W)) u_div_high (
      .clock     (clock),
      .reset     (reset),
      .start     (cmd.div_start),
      .round_up  (1'b1),
      .numerator (hi_num),
      .divisor   (gap),
      .done      (hi_done),
      .quotient  (hi_quo)
   );

   always_ff @(posedge clock) begin
      if (cmd.load && not_full) begin
         mem[count_ff[IDX_W-1:0]] <= req_tdata;
      end
      rd_data_ff <= mem[rd_addr];
   end

   always_comb begin
      count_in      = count_ff;
      v_in          = v_ff;
      i_in          = i_ff;
      step_in       = step_ff;
      sign_in       = sign_ff;
      low_in        = low_ff;
      high_in       = high_ff;
      mid_in        = mid_ff;
      av_in         = av_ff;
      anchor_in     = anchor_ff;
      slope_low_in  = slope_low_ff;
      slope_high_in = slope_high_ff;
      out_valid_in  = out_valid_ff && !rsp_tready;
      out_data_in   = out_data_ff;

      if (cmd.load && not_full) begin
         count_in = count_ff + 1'b1;
      end
      if (cmd.search_init) begin
         low_in  = '0;
         high_in = '1;
         step_in = '0;
      end
      if (cmd.calc_mid) begin
         mid_in  = mid_sum[DEV_W:1];
         v_in    = '0;
         sign_in = 1'b0;
      end
      if (cmd.anchor_ld) begin
         av_in = rd_data_ff;
      end
      if (cmd.anchor_init) begin
         anchor_in     = sign_ff ? scaled_v - x_ext : scaled_v + x_ext;
         slope_low_in  = SLOPE_MIN;
         slope_high_in = SLOPE_MAX;
         i_in          = '0;
      end
      if (cmd.next_sample) begin
         i_in = i_ff + 1'b1;
      end
      if (cmd.slope_update) begin
         if (lo_quo > slope_low_ff) begin
            slope_low_in = lo_quo;
         end
         if (hi_quo < slope_high_ff) begin
            slope_high_in = hi_quo;
         end
      end
      if (cmd.flip_sign) begin
         sign_in = 1'b1;
      end
      if (cmd.next_anchor) begin
         v_in    = v_ff + 1'b1;
         sign_in = 1'b0;
      end
      if (cmd.set_high) begin
         high_in = mid_ff;
         step_in = step_ff + 1'b1;
      end
      if (cmd.set_low) begin
         low_in  = mid_ff;
         step_in = step_ff + 1'b1;
      end
      if (cmd.finish) begin
         count_in     = '0;
         out_valid_in = 1'b1;
         out_data_in  = high_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         low_ff       <= '0;
         high_ff      <= '1;
         out_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         low_ff       <= low_in;
         high_ff      <= high_in;
         out_valid_ff <= out_valid_in;
      end
      v_ff          <= v_in;
      i_ff          <= i_in;
      step_ff       <= step_in;
      sign_ff       <= sign_in;
      mid_ff        <= mid_in;
      av_ff         <= av_in;
      anchor_ff     <= anchor_in;
      slope_low_ff  <= slope_low_in;
      slope_high_ff <= slope_high_in;
      out_data_ff   <= out_data_in;
   end

   always_comb begin
      status.last_i      = (i_ff == count_ff);
      status.i_is_v      = (i_ff == v_ff);
      status.div_done    = lo_done && hi_done;
      status.fits        = (slope_low_ff <= slope_high_ff);
      status.sign        = sign_ff;
      status.last_anchor = (CNT_W'(v_ff + 1'b1) == count_ff);
      status.last_step   = (step_ff == STEP_W'(BISECT_STEPS - 1));
      status.out_free    = !out_valid_ff || rsp_tready;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_data_ff;

endmodule

FILE: rtl/minimax_progression_fit.sv
// Minimax arithmetic-progression fit. Samples stream in one word per cycle and are stored
// in order, up to MAX_SAMPLES (later ones are dropped); the word with tlast set starts a
// bisection search of BISECT_STEPS steps for the smallest deviation, in unsigned Q32.16,
// that lets every sample move onto one arithmetic progression, and one result word follows.
// The search time is set by a bit-serial divider pair, which tests every other sample against
// an anchor; each bisection step runs up to 2n anchor passes over n samples and stops at
// the first anchor that fits. No input is taken during the search;
// the result register lets the next set load while the result waits.
module minimax_progression_fit
   import mpf_pkg::*;
#(
   parameter int MAX_SAMPLES  = 1024,
   parameter int BISECT_STEPS = 48
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_tvalid,
   output logic                req_tready,
   input  logic [SAMPLE_W-1:0] req_tdata,   // [31:0] sample
   input  logic                req_tlast,
   output logic                rsp_tvalid,
   input  logic                rsp_tready,
   output logic [DEV_W-1:0]    rsp_tdata    // [47:0] min_deviation
);

   cmd_type    cmd;
   status_type status;

   mpf_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tlast  (req_tlast),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   mpf_datapath #(
      .MAX_SAMPLES  (MAX_SAMPLES),
      .BISECT_STEPS (BISECT_STEPS)
   ) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .status     (status),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

endmodule

FILE: rtl/mpf_checker.sv
`include "minimax_progression_fit_macros.svh"

module mpf_checker
   import mpf_pkg::*;
(
   input logic                clock,
   input logic                reset,
   input logic                req_tvalid,
   input logic                req_tready,
   input logic                req_tlast,
   input logic                rsp_tvalid,
   input logic                rsp_tready,
   input logic [DEV_W-1:0]    rsp_tdata
);

   `MPF_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid)
   `MPF_ASSERT_NEXT(a_rsp_stable, clock, reset, rsp_tvalid && !rsp_tready, $stable(rsp_tdata))
   `MPF_ASSERT_NOW(a_reset_idle, clock, 1'b0, $past(reset), !rsp_tvalid)
   `MPF_ASSERT_NEXT(a_search_busy, clock, reset, req_tvalid && req_tready && req_tlast, !req_tready)

endmodule

bind minimax_progression_fit mpf_checker u_mpf_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .req_tlast  (req_tlast),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

FILE: tb/minimax_progression_fit_test.sv
module minimax_progression_fit_test;
   import mpf_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int MAX_SAMPLES = 1024;
   localparam int SEARCH_STEPS = 48;
   localparam logic [DEV_W-1:0] DEV_ALL_ONES = {DEV_W{1'b1}};

   typedef struct packed {
      logic [SAMPLE_W-1:0] sample;
      logic                last;
   } sample_word_type;

   logic                clock;
   logic                reset;
   logic                req_tvalid;
   logic                req_tready;
   logic [SAMPLE_W-1:0] req_tdata;
   logic                req_tlast;
   logic                rsp_tvalid;
   logic                rsp_tready;
   logic [DEV_W-1:0]    rsp_tdata;

   sample_word_type  pending_words[$];
   logic [DEV_W-1:0] expected_deviations[$];
   longint           loaded_samples[$];
   int               error_count;
   int               set_count;
   int               word_count;
   int               result_count;
   int               cycle_count;
   int               rsp_hold;
   bit               rsp_hold_request;

   minimax_progression_fit dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic longint floor_div(longint num, longint den);
      longint q;
      q = num / den;
      if ((num % den) != 0 && num < 0) q--;
      return q;
   endfunction

   function automatic longint ceil_div(longint num, longint den);
      longint q;
      q = num / den;
      if ((num % den) != 0 && num > 0) q++;
      return q;
   endfunction

   function automatic bit anchor_feasible(int v, longint anchor, longint x);
      longint lo_slope;
      longint hi_slope;
      longint lo_pt;
      longint hi_pt;
      longint lo_b;
      longint hi_b;
      longint d;
      lo_slope = 64'sh8000_0000_0000_0000;
      hi_slope = 64'sh7FFF_FFFF_FFFF_FFFF;
      for (int i = 0; i < loaded_samples.size(); i++) begin
         if (i == v) continue;
         lo_pt = loaded_samples[i] * 65536 - x;
         hi_pt = loaded_samples[i] * 65536 + x;
         if (i < v) begin
            d = v - i;
            lo_b = floor_div(anchor - hi_pt, d);
            hi_b = ceil_div(anchor - lo_pt, d);
         end else begin
            d = i - v;
            lo_b = floor_div(lo_pt - anchor, d);
            hi_b = ceil_div(hi_pt - anchor, d);
         end
         if (lo_b > lo_slope) lo_slope = lo_b;
         if (hi_b < hi_slope) hi_slope = hi_b;
      end
      return lo_slope <= hi_slope;
   endfunction

   function automatic bit deviation_feasible(logic [DEV_W-1:0] dev);
      longint x;
      longint centre;
      x = longint'({16'd0, dev});
      for (int v = 0; v < loaded_samples.size(); v++) begin
         centre = loaded_samples[v] * 65536;
         if (anchor_feasible(v, centre + x, x)) return 1'b1;
         if (anchor_feasible(v, centre - x, x)) return 1'b1;
      end
      return 1'b0;
   endfunction

   function automatic logic [DEV_W-1:0] min_deviation();
      logic [DEV_W:0]   sum;
      logic [DEV_W-1:0] lo;
      logic [DEV_W-1:0] hi;
      logic [DEV_W-1:0] mid;
      lo = '0;
      hi = DEV_ALL_ONES;
      for (int s = 0; s < SEARCH_STEPS; s++) begin
         sum = {1'b0, lo} + {1'b0, hi};
         mid = sum[DEV_W:1];
         if (deviation_feasible(mid)) hi = mid;
         else lo = mid;
      end
      return hi;
   endfunction

   task automatic take_word(logic [SAMPLE_W-1:0] sample, logic last);
      word_count++;
      if (loaded_samples.size() < MAX_SAMPLES)
         loaded_samples = {loaded_samples, longint'($signed(sample))};
      if (last) begin
         expected_deviations = {expected_deviations, min_deviation()};
         loaded_samples.delete();
         set_count++;
      end
   endtask

   task automatic report_mismatch(string what, logic [DEV_W-1:0] got, logic [DEV_W-1:0] want);
      error_count++;
      $display("ERROR %0t: %s got %h expected %h", $realtime, what, got, want);
   endtask

   function automatic bit idle_now();
      if (cycle_count > 20000 && cycle_count < 60000) return 1'b0;
      return $urandom_range(99) < 30;
   endfunction

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (reset) begin
         req_tvalid <= 1'b0;
         req_tdata  <= '0;
         req_tlast  <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) take_word(req_tdata, req_tlast);
         if (!req_tvalid || req_tready) begin
            if (pending_words.size() > 0 && !idle_now()) begin
               req_tvalid <= 1'b1;
               req_tdata  <= pending_words[0].sample;
               req_tlast  <= pending_words[0].last;
               void'(pending_words.pop_front());
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
         rsp_hold   <= 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            result_count++;
            if (expected_deviations.size() == 0) begin
               report_mismatch("unexpected min_deviation", rsp_tdata, '0);
            end else begin
               if (rsp_tdata !== expected_deviations[0])
                  report_mismatch("min_deviation", rsp_tdata, expected_deviations[0]);
               void'(expected_deviations.pop_front());
            end
         end
         if (rsp_hold_request && rsp_hold == 0) begin
            rsp_hold   <= 30000;
            rsp_tready <= 1'b0;
         end else if (rsp_hold > 0) begin
            rsp_hold   <= rsp_hold - 1;
            rsp_tready <= (rsp_hold == 1);
         end else begin
            rsp_tready <= !idle_now();
         end
      end
   end

   always @(posedge clock) if (rsp_hold > 0) rsp_hold_request <= 1'b0;

   function automatic logic [SAMPLE_W-1:0] random_sample();
      case ($urandom_range(3))
         0: return $urandom();
         1: return $urandom_range(40) - 20;
         2: return $urandom_range(2000) - 1000;
         default: return $urandom_range(1) ? 32'h8000_0000 + $urandom_range(15)
                                           : 32'h7FFF_FFFF - $urandom_range(15);
      endcase
   endfunction

   task automatic queue_set(int n);
      sample_word_type w;
      for (int i = 0; i < n; i++) begin
         w.sample = random_sample();
         w.last   = (i == n - 1);
         pending_words = {pending_words, w};
      end
   endtask

   task automatic queue_word(logic [SAMPLE_W-1:0] sample, logic last);
      sample_word_type w;
      w.sample = sample;
      w.last   = last;
      pending_words = {pending_words, w};
   endtask

   initial begin
      int queued;
      int n;
      int roll;
      error_count      = 0;
      set_count        = 0;
      word_count       = 0;
      result_count     = 0;
      cycle_count      = 0;
      rsp_hold_request = 1'b0;
      reset            = 1'b1;
      req_tvalid       = 1'b0;
      req_tdata        = '0;
      req_tlast        = 1'b0;
      rsp_tready       = 1'b0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      queue_word(32'h0000_0000, 1'b1);
      queue_word(32'h8000_0000, 1'b1);
      queue_word(32'h7FFF_FFFF, 1'b1);
      queue_word(32'h8000_0000, 1'b0);
      queue_word(32'h7FFF_FFFF, 1'b1);
      queue_word(32'h7FFF_FFFF, 1'b0);
      queue_word(32'h8000_0000, 1'b1);
      queue_word(32'd5, 1'b0);
      queue_word(32'd5, 1'b1);
      queue_word(32'd1, 1'b0);
      queue_word(32'd4, 1'b0);
      queue_word(32'd2, 1'b1);
      queue_word(32'h8000_0000, 1'b0);
      queue_word(32'h7FFF_FFFF, 1'b0);
      queue_word(32'h8000_0000, 1'b1);
      queue_word(32'hFFFF_FFFF, 1'b0);
      queue_word(32'h5555_5555, 1'b0);
      queue_word(32'hAAAA_AAAA, 1'b1);
      queued = pending_words.size();
      wait (pending_words.size() == 0 && expected_deviations.size() == 0);

      rsp_hold_request = 1'b1;
      while (queued < 1750) begin
         roll = $urandom_range(99);
         n = (roll < 50) ? 1 : (roll < 88) ? 2 : 3;
         queue_set(n);
         queued += n;
         while (pending_words.size() > 40) @(posedge clock);
      end

      wait (pending_words.size() == 0 && !req_tvalid && expected_deviations.size() == 0);
      repeat (200) @(posedge clock);
      $display("Covered %0d sample words in %0d sets of one to three samples, %0d results,",
               word_count, set_count, result_count);
      $display("with field extremes, random stalls and one long result back-pressure hold.");
      if (error_count == 0) begin
         $display("minimax_progression_fit_test passed");
      end else begin
         $display("minimax_progression_fit_test failed");
      end
      $finish;
   end

   initial begin
      #1000ms;
      $display("minimax_progression_fit_test failed");
      $finish;
   end

endmodule
